/* hdl/digit_bucket_range_counter_unit_macros.svh */
// Assertion helpers for the digit bucket range counter.
`ifndef DIGIT_BUCKET_RANGE_COUNTER_UNIT_MACROS_SVH
`define DIGIT_BUCKET_RANGE_COUNTER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DBRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DBRC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/dbrc_pkg.sv */
`timescale 1ns / 1ps
package dbrc_pkg;

   localparam int MaxEntriesDefault  = 1024;
   localparam int DigitPlacesDefault = 10;
   localparam int Radix              = 10;
   localparam int ValueWidth         = 31;
   localparam int PosWidth           = 11;
   localparam int CountWidth         = 11;

   localparam logic REQ_SET   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SPLIT,
      ST_CHECK,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_QRY_RD,
      ST_QRY_ACC,
      ST_DONE
   } state_type;

endpackage

/* hdl/digit_bucket_range_counter_unit.sv */
`timescale 1ns / 1ps
// Digit bucket range counter.
// Requests enter on req_tvalid/req_tready/req_tdata; req_tuser carries the
// request type (0 set, 1 query). One response per request leaves on the rsp_
// channel: match_count and status. csr_we/csr_wdata write entries_in_use and
// may only be used while the block is idle.
// After reset the block sweeps its count memory, one word per cycle, through
// all (MAX_ENTRIES+1)*DIGIT_PLACES*10 words, with req_tready low throughout.
// A set splits the old and new values into digits (one digit of each a cycle
// through a divide-by-ten step per value), then walks the Fenwick tree of each
// changed place: a read and a write state per node, up to log2(MAX_ENTRIES)+1
// nodes per walk, one walk to remove the old digit and one to add the new (only
// the add walk on a first load). A query walks two prefix paths, a read and an
// accumulate state per node. The count memory is single-port.
// A finished response moves to an output register; a stalled receiver holds it
// there, and the next request is accepted and worked on but waits for that
// register to empty before its own response goes out.
module digit_bucket_range_counter_unit #(
   parameter int MAX_ENTRIES  = dbrc_pkg::MaxEntriesDefault,
   parameter int DIGIT_PLACES = dbrc_pkg::DigitPlacesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // position[10:0], new_value[41:11], range_left[52:42], range_right[63:53],
   // digit_place[67:64], digit_wanted[71:68]
   input  logic [71:0] req_tdata,
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // match_count[10:0], status[11]
   input  logic        csr_we,
   input  logic [10:0] csr_wdata    // entries_in_use
);

   localparam int IdxW    = $clog2(MAX_ENTRIES + 1);
   localparam int PlW     = (DIGIT_PLACES > 1) ? $clog2(DIGIT_PLACES) : 1;
   localparam int TreeW   = PlW + 4;
   localparam int Words   = DIGIT_PLACES * dbrc_pkg::Radix * (MAX_ENTRIES + 1);
   localparam int AddrW   = $clog2(Words);
   localparam int PW      = dbrc_pkg::PosWidth;
   localparam int VW      = dbrc_pkg::ValueWidth;
   localparam int CW      = dbrc_pkg::CountWidth;
   localparam int TrW     = DIGIT_PLACES * dbrc_pkg::Radix;

   // Memories
   logic [VW-1:0] val_mem [MAX_ENTRIES+1];
   logic          ld_mem  [MAX_ENTRIES+1];
   logic [CW-1:0] cnt_mem [Words];

   dbrc_pkg::state_type state_ff, state_in;

   logic [CW-1:0]   limit_ff, limit_in;
   logic            type_ff, type_in;
   logic [IdxW-1:0] pos_ff, pos_in;
   logic [VW-1:0]   nval_ff, nval_in;
   logic [IdxW-1:0] lft_ff, lft_in, rgt_ff, rgt_in;
   logic [PlW-1:0]  qpl_ff, qpl_in;
   logic [3:0]      qdg_ff, qdg_in;
   logic [VW-1:0]   oval_ff;
   logic            loaded_ff;
   logic [VW-1:0]   nwork_ff, nwork_in, owork_ff, owork_in;
   logic [3:0]      odig_ff [DIGIT_PLACES];
   logic [3:0]      ndig_ff [DIGIT_PLACES];
   logic [PlW-1:0]  pl_ff, pl_in;
   logic            phase_ff, phase_in;   // set: 0 remove old, 1 add new
   logic [IdxW:0]   idx_ff, idx_in;
   logic [AddrW-1:0] clr_ff, clr_in;
   logic [CW-1:0]   acc_ff, acc_in;
   logic [CW-1:0]   rdata_ff;
   logic [CW-1:0]   cnt_out_ff, cnt_out_in;
   logic            st_out_ff, st_out_in;
   logic            rsp_v_ff, rsp_v_in;
   logic [CW-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic            rsp_st_ff, rsp_st_in;

   // Decimal split step, one per value
   logic [VW-1:0] nq, oq;
   logic [3:0]    nr, orr;
   logic [VW+3:0] nprod, oprod;
   logic [VW-1:0] osrc;

   logic [IdxW-1:0] lim_eff;
   logic            acc_req;
   logic [IdxW-1:0] r_pos, r_lft, r_rgt;
   logic [3:0]      r_pl, r_dg;
   logic            bad;

   logic [TreeW-1:0] tree_sel;
   logic [AddrW-1:0] addr;
   logic             mem_we;
   logic [CW-1:0]    mem_wd;
   logic [IdxW:0]    low_bit;
   logic             walk_end;
   logic             place_diff;

   assign acc_req = req_tvalid && req_tready;
   assign lim_eff = (limit_ff > CW'(MAX_ENTRIES)) ? IdxW'(MAX_ENTRIES) : IdxW'(limit_ff);

   assign r_pos = (req_tdata[10:0]  > 11'(MAX_ENTRIES)) ? '0 : IdxW'(req_tdata[10:0]);
   assign r_lft = (req_tdata[52:42] > 11'(MAX_ENTRIES)) ? '0 : IdxW'(req_tdata[52:42]);
   assign r_rgt = (req_tdata[63:53] > 11'(MAX_ENTRIES)) ? '0 : IdxW'(req_tdata[63:53]);
   assign r_pl  = req_tdata[67:64];
   assign r_dg  = req_tdata[71:68];

   always_comb begin
      if (req_tuser == dbrc_pkg::REQ_SET) begin
         bad = (r_pos == '0) || (r_pos > lim_eff);
      end else begin
         bad = (r_lft == '0) || (r_lft > lim_eff) || (r_rgt == '0) || (r_rgt > lim_eff) ||
               (r_pl == 4'd0) || (r_pl > 4'(DIGIT_PLACES)) ||
               (r_dg >= 4'(dbrc_pkg::Radix));
      end
   end

   // The stored value is registered into oval_ff from pos_ff during ST_READ; feed
   // it in directly on the first split step.
   assign osrc = (state_ff == dbrc_pkg::ST_SPLIT && pl_ff == '0) ? oval_ff : owork_ff;

   // Divide by ten through a reciprocal multiply and shift; the remainder is the digit.
   always_comb begin
      nq    = VW'((64'(nwork_ff) * 64'hCCCC_CCCD) >> 35);
      oq    = VW'((64'(osrc) * 64'hCCCC_CCCD) >> 35);
      nprod = (VW+4)'(nq) * (VW+4)'(dbrc_pkg::Radix);
      oprod = (VW+4)'(oq) * (VW+4)'(dbrc_pkg::Radix);
      nr    = 4'((VW+4)'(nwork_ff) - nprod);
      orr   = 4'((VW+4)'(osrc) - oprod);
   end

   assign low_bit    = idx_ff & ((IdxW+1)'(0) - idx_ff);
   assign place_diff = !loaded_ff || (odig_ff[pl_ff] != ndig_ff[pl_ff]);

   always_comb begin
      if (type_ff == dbrc_pkg::REQ_QUERY) begin
         tree_sel = TreeW'(qpl_ff) * TreeW'(dbrc_pkg::Radix) + TreeW'(qdg_ff);
      end else if (phase_ff) begin
         tree_sel = TreeW'(pl_ff) * TreeW'(dbrc_pkg::Radix) + TreeW'(ndig_ff[pl_ff]);
      end else begin
         tree_sel = TreeW'(pl_ff) * TreeW'(dbrc_pkg::Radix) + TreeW'(odig_ff[pl_ff]);
      end
   end

   always_comb begin
      if (state_ff == dbrc_pkg::ST_CLEAR) begin
         addr = clr_ff;
      end else begin
         addr = AddrW'(tree_sel) * AddrW'(MAX_ENTRIES + 1) + AddrW'(idx_ff);
      end
   end

   always_comb begin
      mem_we = (state_ff == dbrc_pkg::ST_CLEAR) || (state_ff == dbrc_pkg::ST_RMW_WR);
      if (state_ff == dbrc_pkg::ST_CLEAR) begin
         mem_wd = '0;
      end else if (phase_ff) begin
         mem_wd = rdata_ff + CW'(1);
      end else begin
         mem_wd = rdata_ff - CW'(1);
      end
   end

   assign walk_end = (type_ff == dbrc_pkg::REQ_QUERY) ?
                     ((idx_ff - low_bit) == '0) :
                     ((idx_ff + low_bit) > (IdxW+1)'(MAX_ENTRIES));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem[addr] <= mem_wd;
      end
      rdata_ff <= cnt_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == dbrc_pkg::ST_CLEAR) begin
         ld_mem[clr_ff[IdxW-1:0]] <= 1'b0;
      end else if (state_ff == dbrc_pkg::ST_DONE && type_ff == dbrc_pkg::REQ_SET &&
                   !st_out_ff) begin
         ld_mem[pos_ff]  <= 1'b1;
         val_mem[pos_ff] <= nval_ff;
      end
      oval_ff   <= val_mem[pos_ff];
      loaded_ff <= ld_mem[pos_ff];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dbrc_pkg::ST_CLEAR: begin
            if (clr_ff == AddrW'(Words - 1)) state_in = dbrc_pkg::ST_IDLE;
         end
         dbrc_pkg::ST_IDLE: begin
            if (acc_req) begin
               if (bad) state_in = dbrc_pkg::ST_DONE;
               else if (req_tuser == dbrc_pkg::REQ_SET) state_in = dbrc_pkg::ST_READ;
               else if (r_lft > r_rgt) state_in = dbrc_pkg::ST_DONE;
               else state_in = dbrc_pkg::ST_QRY_RD;
            end
         end
         dbrc_pkg::ST_READ: state_in = dbrc_pkg::ST_SPLIT;
         dbrc_pkg::ST_SPLIT: begin
            if (pl_ff == PlW'(DIGIT_PLACES - 1)) state_in = dbrc_pkg::ST_CHECK;
         end
         dbrc_pkg::ST_CHECK: begin
            if (loaded_ff && oval_ff == nval_ff) state_in = dbrc_pkg::ST_DONE;
            else if (place_diff) state_in = dbrc_pkg::ST_RMW_RD;
            else if (pl_ff == PlW'(DIGIT_PLACES - 1)) state_in = dbrc_pkg::ST_DONE;
         end
         dbrc_pkg::ST_RMW_RD: state_in = dbrc_pkg::ST_RMW_WR;
         dbrc_pkg::ST_RMW_WR: begin
            if (walk_end) begin
               if (phase_ff && pl_ff == PlW'(DIGIT_PLACES - 1)) state_in = dbrc_pkg::ST_DONE;
               else if (phase_ff) state_in = dbrc_pkg::ST_CHECK;
               else state_in = dbrc_pkg::ST_RMW_RD;
            end else begin
               state_in = dbrc_pkg::ST_RMW_RD;
            end
         end
         dbrc_pkg::ST_QRY_RD: state_in = dbrc_pkg::ST_QRY_ACC;
         dbrc_pkg::ST_QRY_ACC: begin
            if (walk_end && (phase_ff || lft_ff == IdxW'(1))) state_in = dbrc_pkg::ST_DONE;
            else state_in = dbrc_pkg::ST_QRY_RD;
         end
         dbrc_pkg::ST_DONE: begin
            if (!rsp_v_ff || rsp_tready) state_in = dbrc_pkg::ST_IDLE;
         end
         default: state_in = dbrc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      limit_in   = csr_we ? csr_wdata : limit_ff;
      type_in    = type_ff;
      pos_in     = pos_ff;
      nval_in    = nval_ff;
      lft_in     = lft_ff;
      rgt_in     = rgt_ff;
      qpl_in     = qpl_ff;
      qdg_in     = qdg_ff;
      nwork_in   = nwork_ff;
      owork_in   = owork_ff;
      pl_in      = pl_ff;
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      clr_in     = clr_ff;
      acc_in     = acc_ff;
      cnt_out_in = cnt_out_ff;
      st_out_in  = st_out_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_st_in  = rsp_st_ff;
      rsp_v_in   = (rsp_v_ff && !rsp_tready);
      req_tready = (state_ff == dbrc_pkg::ST_IDLE);
      unique case (state_ff)
         dbrc_pkg::ST_CLEAR: clr_in = clr_ff + AddrW'(1);
         dbrc_pkg::ST_IDLE: begin
            if (acc_req) begin
               type_in    = req_tuser;
               pos_in     = r_pos;
               nval_in    = req_tdata[41:11];
               lft_in     = r_lft;
               rgt_in     = r_rgt;
               qpl_in     = PlW'(r_pl - 4'd1);
               qdg_in     = r_dg;
               st_out_in  = bad;
               cnt_out_in = '0;
               acc_in     = '0;
               pl_in      = '0;
               phase_in   = 1'b0;
               idx_in     = (IdxW+1)'(r_rgt);
               nwork_in   = req_tdata[41:11];
            end
         end
         dbrc_pkg::ST_SPLIT: begin
            nwork_in = nq;
            owork_in = oq;
            if (pl_ff == PlW'(DIGIT_PLACES - 1)) pl_in = '0;
            else pl_in = pl_ff + PlW'(1);
         end
         dbrc_pkg::ST_CHECK: begin
            idx_in   = (IdxW+1)'(pos_ff);
            phase_in = !loaded_ff;
            if (!place_diff && pl_ff != PlW'(DIGIT_PLACES - 1)) pl_in = pl_ff + PlW'(1);
         end
         dbrc_pkg::ST_RMW_WR: begin
            if (walk_end) begin
               idx_in = (IdxW+1)'(pos_ff);
               if (phase_ff) begin
                  phase_in = 1'b0;
                  if (pl_ff != PlW'(DIGIT_PLACES - 1)) pl_in = pl_ff + PlW'(1);
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               idx_in = idx_ff + low_bit;
            end
         end
         dbrc_pkg::ST_QRY_ACC: begin
            // Right prefix adds, left prefix subtracts.
            if (phase_ff) acc_in = acc_ff - rdata_ff;
            else acc_in = acc_ff + rdata_ff;
            if (walk_end) begin
               phase_in = 1'b1;
               idx_in   = (IdxW+1)'(lft_ff - IdxW'(1));
               if (lft_ff == IdxW'(1) || phase_ff) cnt_out_in = acc_in;
            end else begin
               idx_in = idx_ff - low_bit;
            end
         end
         dbrc_pkg::ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in   = 1'b1;
               rsp_cnt_in = cnt_out_ff;
               rsp_st_in  = st_out_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbrc_pkg::ST_CLEAR;
         limit_ff <= CW'(1024);
         clr_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         clr_ff   <= clr_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      pos_ff     <= pos_in;
      nval_ff    <= nval_in;
      lft_ff     <= lft_in;
      rgt_ff     <= rgt_in;
      qpl_ff     <= qpl_in;
      qdg_ff     <= qdg_in;
      nwork_ff   <= nwork_in;
      owork_ff   <= owork_in;
      pl_ff      <= pl_in;
      phase_ff   <= phase_in;
      idx_ff     <= idx_in;
      acc_ff     <= acc_in;
      cnt_out_ff <= cnt_out_in;
      st_out_ff  <= st_out_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_st_ff  <= rsp_st_in;
      if (state_ff == dbrc_pkg::ST_SPLIT) begin
         ndig_ff[pl_ff] <= nr;
         odig_ff[pl_ff] <= orr;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {4'd0, rsp_st_ff, rsp_cnt_ff};

   // Sanity checks
   `include "digit_bucket_range_counter_unit_macros.svh"

   `DBRC_ASSERT(a_no_accept_busy, clock, reset, req_tready |-> state_ff == dbrc_pkg::ST_IDLE, "ready outside idle")
   `DBRC_ASSERT(a_rsp_only_done, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff) == dbrc_pkg::ST_DONE, "response without completion")
   `DBRC_ASSERT(a_bad_zero, clock, reset, (rsp_tvalid && rsp_st_ff) |-> rsp_cnt_ff == '0, "rejected request with nonzero count")
   `DBRC_ASSERT_ALWAYS(a_reset_clear, clock, $past(reset) |-> !rsp_tvalid, "response right after reset")

endmodule

/* dv/dbrc_checker.sv */
`timescale 1ns / 1ps
module dbrc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   output int          failures,
   output int          outstanding
);

   localparam int Slots = dbrc_pkg::MaxEntriesDefault;

   typedef struct packed {
      logic [dbrc_pkg::CountWidth-1:0] match_count;
      logic                            status;
   } outcome_type;

   outcome_type                     outcome_q[$];
   logic [dbrc_pkg::ValueWidth-1:0] slot_value [1:Slots];
   logic                            slot_loaded[1:Slots];
   logic [10:0]                     entries_reg;

   function automatic int digit_at(input logic [dbrc_pkg::ValueWidth-1:0] v, input int place);
      int unsigned x;
      x = 32'(v);
      for (int p = 1; p < place; p++) x = x / dbrc_pkg::Radix;
      return int'(x % dbrc_pkg::Radix);
   endfunction

   // Apply one request to the shadow array and return the response it should give.
   function automatic outcome_type apply_request(input logic kind, input logic [71:0] d);
      outcome_type                     res;
      int                              lim, cnt;
      logic [10:0]                     pos, lft, rgt;
      logic [dbrc_pkg::ValueWidth-1:0] val;
      logic [3:0]                      plc, dgw;
      pos = d[10:0];
      val = d[41:11];
      lft = d[52:42];
      rgt = d[63:53];
      plc = d[67:64];
      dgw = d[71:68];
      lim = (int'(entries_reg) > Slots) ? Slots : int'(entries_reg);
      res.match_count = '0;
      res.status = dbrc_pkg::STATUS_OK;
      if (kind == dbrc_pkg::REQ_SET) begin
         if (pos < 1 || pos > lim) res.status = dbrc_pkg::STATUS_BAD;
         else begin
            slot_value[pos] = val;
            slot_loaded[pos] = 1'b1;
         end
      end else begin
         if (lft < 1 || lft > lim || rgt < 1 || rgt > lim || plc < 1 ||
             plc > dbrc_pkg::DigitPlacesDefault || dgw >= dbrc_pkg::Radix) begin
            res.status = dbrc_pkg::STATUS_BAD;
         end else begin
            cnt = 0;
            for (int i = lft; i <= rgt; i++)
               if (slot_loaded[i] && digit_at(slot_value[i], plc) == dgw) cnt++;
            res.match_count = cnt[dbrc_pkg::CountWidth-1:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         outcome_q.delete();
         for (int i = 1; i <= Slots; i++) slot_loaded[i] = 1'b0;
         entries_reg = 11'd1024;
         failures = 0;
      end else begin
         if (csr_we) entries_reg = csr_wdata;
         if (req_tvalid && req_tready) outcome_q.push_back(apply_request(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $error("response with no request pending: %h", rsp_tdata);
               failures++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tdata[10:0] !== want.match_count) begin
                  $error("match_count expected %0d actual %0d", want.match_count,
                         rsp_tdata[10:0]);
                  failures++;
               end
               if (rsp_tdata[11] !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_tdata[11]);
                  failures++;
               end
            end
         end
      end
      outstanding = outcome_q.size();
   end
endmodule

/* dv/digit_bucket_range_counter_unit_tb.sv */
`timescale 1ns / 1ps
module digit_bucket_range_counter_unit_tb;

   localparam int StallLimit = 400000;
   localparam int HoldCycles = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = dbrc_pkg::REQ_SET;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;

   int failures, outstanding;
   int send_idle_pct, rsp_stall_pct;
   int hold_asks, hold_seen, hold_left;
   int quiet_cycles;
   int lim_now;
   logic [30:0] written_value[1:1024];
   logic        written[1:1024];

   digit_bucket_range_counter_unit u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_wdata
   );

   dbrc_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_wdata,
      .failures, .outstanding
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off when asked.
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send(input logic kind, input logic [10:0] pos, input logic [30:0] val,
                       input logic [10:0] lft, input logic [10:0] rgt,
                       input logic [3:0] plc, input logic [3:0] dgw);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {dgw, plc, rgt, lft, val, pos};
      do @(posedge clock); while (!req_tready);
      if (kind == dbrc_pkg::REQ_SET && pos >= 1 && pos <= lim_now) begin
         written[pos] = 1'b1;
         written_value[pos] = val;
      end
      @(negedge clock);
   endtask

   task automatic drain(input int tail);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   task automatic write_limit(input logic [10:0] v);
      drain(300);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      lim_now = (v > 1024) ? 1024 : int'(v);
   endtask

   function automatic logic [10:0] pick_pos(input int lim);
      int r;
      r = $urandom_range(99);
      if (r < 4) return 11'd0;
      if (r < 8) return 11'($urandom_range(2047));
      if (lim == 0) return 11'($urandom_range(2047));
      return 11'($urandom_range(lim, 1));
   endfunction

   function automatic logic [30:0] pick_value(input logic [10:0] pos);
      int r, k;
      logic [30:0] base;
      int unsigned step;
      r = $urandom_range(99);
      base = (pos >= 1 && pos <= 1024 && written[pos]) ? written_value[pos] : 31'd0;
      if (r < 10) return base;
      if (r < 45) begin
         step = 1;
         k = $urandom_range(9);
         for (int i = 0; i < k; i++) step = step * 10;
         return 31'(base + step);
      end
      if (r < 65) return 31'($urandom_range(999));
      if (r < 70) return 31'h7fffffff;
      return 31'($urandom);
   endfunction

   task automatic random_request();
      logic [10:0] pos, lft, rgt;
      logic [3:0]  plc, dgw;
      if ($urandom_range(1)) begin
         pos = pick_pos(lim_now);
         send(dbrc_pkg::REQ_SET, pos, pick_value(pos), 11'($urandom), 11'($urandom),
              4'($urandom), 4'($urandom));
      end else begin
         lft = pick_pos(lim_now);
         rgt = pick_pos(lim_now);
         if ($urandom_range(3) == 0 && lft > rgt) {lft, rgt} = {rgt, lft};
         plc = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(10, 1));
         dgw = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(9));
         send(dbrc_pkg::REQ_QUERY, 11'($urandom), 31'($urandom), lft, rgt, plc, dgw);
      end
   endtask

   initial begin
      logic [10:0] limits[8];
      int          idle_pcts[8], stall_pcts[8];
      limits     = '{11'd1024, 11'd16, 11'd2047, 11'd1, 11'd2, 11'd200, 11'd64, 11'd1024};
      idle_pcts  = '{0, 74, 0, 28, 0, 74, 0, 28};
      stall_pcts = '{0, 0, 74, 28, 0, 0, 74, 28};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_asks = 0;
      lim_now = 1024;
      for (int i = 1; i <= 1024; i++) written[i] = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, bad operands, rewrites, empty range
      send(dbrc_pkg::REQ_SET, 11'd1, 31'd0, '0, '0, '0, '0);
      send(dbrc_pkg::REQ_SET, 11'd1024, 31'h7fffffff, '0, '0, '0, '0);
      send(dbrc_pkg::REQ_SET, 11'd0, 31'd5, '0, '0, '0, '0);
      send(dbrc_pkg::REQ_SET, 11'd2047, 31'd5, '0, '0, '0, '0);
      send(dbrc_pkg::REQ_SET, 11'd2, 31'd1234567890, '0, '0, '0, '0);
      send(dbrc_pkg::REQ_SET, 11'd2, 31'd1234567890, '0, '0, '0, '0);
      send(dbrc_pkg::REQ_SET, 11'd2, 31'd1234567891, '0, '0, '0, '0);
      send(dbrc_pkg::REQ_SET, 11'd2, 31'd987654321, '0, '0, '0, '0);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1, 11'd1024, 4'd1, 4'd0);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1, 11'd1024, 4'd10, 4'd2);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1024, 11'd1024, 4'd10, 4'd2);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd3, 11'd2, 4'd1, 4'd1);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd0, 11'd5, 4'd1, 4'd1);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1, 11'd1025, 4'd1, 4'd1);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1, 11'd5, 4'd0, 4'd1);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1, 11'd5, 4'd11, 4'd1);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1, 11'd5, 4'd15, 4'd15);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1, 11'd5, 4'd3, 4'd10);
      write_limit(11'd0);
      send(dbrc_pkg::REQ_SET, 11'd1, 31'd7, '0, '0, '0, '0);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1, 11'd1, 4'd1, 4'd0);
      write_limit(11'd1);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1, 11'd2, 4'd1, 4'd0);
      send(dbrc_pkg::REQ_QUERY, '0, '0, 11'd1, 11'd1, 4'd1, 4'd0);

      for (int ph = 0; ph < 8; ph++) begin
         write_limit(limits[ph]);
         send_idle_pct = idle_pcts[ph];
         rsp_stall_pct = stall_pcts[ph];
         for (int n = 0; n < 210; n++) begin
            if (ph == 4 && n == 50) hold_asks++;
            if (ph == 6 && n == 100) drain(0);
            random_request();
         end
      end
      send_idle_pct = 0;
      drain(300);
      if (failures == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
